// ===== design/mws_pkg.sv =====
// shared constants for the moving window mean and standard deviation block
// no dependencies; imported by the top level
package mws_pkg;

    localparam int WINDOW_MAX_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_W       = 9;
    localparam int IN_TDATA_W  = 16;
    localparam int MEAN_W      = 24;
    localparam int SD_W        = 24;
    localparam int OUT_TDATA_W = MEAN_W + SD_W;
    localparam int FRAC_BITS   = 8;

endpackage

// ===== design/mws_serial_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// no dependencies; used by moving_window_mean_std_top
module mws_serial_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [AW-1:0]        a,
    input  logic [BW-1:0]        b,
    output logic                 busy,
    output logic [AW+BW-1:0]     product
);

    localparam int CNT_W = $clog2(AW);

    logic [AW+BW-1:0] p_reg, p_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [BW:0]      add;

    always_comb
    begin
        add       = {1'b0, p_reg[AW+BW-1:AW]} + (p_reg[0] ? {1'b0, b_reg} : '0);
        p_next    = p_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            p_next    = {{BW{1'b0}}, a};
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            p_next   = {add, p_reg[AW-1:1]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(AW - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            p_reg    <= p_next;
            b_reg    <= b_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy    = busy_reg;
    assign product = p_reg;

endmodule

// ===== design/mws_serial_div.sv =====
// restoring divider, one quotient bit per cycle
// expects dividend >> Q_W to be below the divisor; no dependencies
module mws_serial_div #(
    parameter int DVS_W = 9,
    parameter int Q_W   = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DVS_W+Q_W-1:0]   dividend,
    input  logic [DVS_W-1:0]       divisor,
    output logic                   busy,
    output logic [Q_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(Q_W);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] diff;
    logic             ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[Q_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        ge        = !diff[DVS_W+1];
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend[DVS_W+Q_W-1:Q_W];
            quo_next  = dividend[Q_W-1:0];
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/mws_serial_sqrt.sv =====
// digit-by-digit integer square root, two radicand bits per cycle
// no dependencies; result truncates
module mws_serial_sqrt #(
    parameter int R = 23
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2*R-1:0]   radicand,
    output logic             busy,
    output logic [R-1:0]     root
);

    localparam int CNT_W = $clog2(R);

    logic [2*R-1:0]   rad_reg, rad_next;
    logic [R+1:0]     rem_reg, rem_next;
    logic [R-1:0]     root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [R+3:0]     rem_sh;
    logic [R+3:0]     trial;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[2*R-1:2*R-2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[2*R-3:0], 2'b00};
            rem_next  = ge ? (R+2)'(rem_sh - trial) : (R+2)'(rem_sh);
            root_next = {root_reg[R-2:0], ge};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(R - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== design/moving_window_mean_std_top.sv =====
// moving window mean and standard deviation over a ring of recent samples
// depends on mws_pkg, mws_serial_mul, mws_serial_div, mws_serial_sqrt
//
//  channel  | side   | payload
//  ---------+--------+------------------------------------------------------
//  s_axis   | in     | tdata: sample
//  m_axis   | out    | tdata: mean, std_dev; tuser: window_full
//  cfg      | in     | data: window_length, write clears the window
//
// one request at a time: each sample runs through the bit-serial squarers,
// multipliers, mean and variance dividers and square root before the next
// is taken; the window clears in the cycle of a cfg write
// a finished result sits in the output register; the next request is taken
// while it waits, and only the final hand-over stalls on m_axis_tready
module moving_window_mean_std_top
    import mws_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [23:0] mean, [47:24] std_dev
    output logic                   m_axis_tuser,   // [0] window_full
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int LOG    = $clog2(WINDOW_MAX);
    localparam int PTR_W  = (LOG > 0) ? LOG : 1;
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int SUM_W  = SB + LOG + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int SQ_W   = 2 * SB - 1 + LOG;
    localparam int LSQ_W  = LEN_W + SQ_W;
    localparam int SSQ_W  = 2 * MAG_W;
    localparam int NUM_W  = (LSQ_W > SSQ_W) ? LSQ_W : SSQ_W;
    localparam int MQ_W   = SB + FRAC_BITS;
    localparam int MEXT_W = (MQ_W + 1 > MEAN_W) ? MQ_W + 1 : MEAN_W;
    localparam int VQ_W   = 2 * SB + 14;
    localparam int VDS_W  = 2 * LEN_W;
    localparam int RT_W   = SB + 7;
    localparam int SDX_W  = (RT_W > SD_W) ? RT_W : SD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SQ,
        S_UPD,
        S_STRT,
        S_MUL,
        S_VDIV,
        S_SQRT,
        S_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [VDS_W-1:0]          len_sq_reg, len_sq_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic [PTR_W-1:0]          wp_reg, wp_next;
    logic [LEN_W-1:0]          fill_reg, fill_next;
    logic signed [SB-1:0]      s_reg, s_next;
    logic [PTR_W-1:0]          pos_reg, pos_next;
    logic signed [SB-1:0]      old_reg, old_next;
    logic [MEAN_W-1:0]         mean_reg, mean_next;
    logic [SD_W-1:0]           sd_reg, sd_next;
    logic                      full_reg, full_next;
    logic                      m_valid_reg, m_valid_next;

    logic [SB-1:0]             ring [WINDOW_MAX];
    logic [SB-1:0]             rd_data_reg;

    logic                      in_acc;
    logic                      cfg_acc;
    logic [CMP_W-1:0]          cfg_ext;
    logic [LEN_W-1:0]          len_eff;
    logic [PTR_W-1:0]          pos_sel;
    logic [SB-1:0]             raw;
    logic signed [SB-1:0]      old_val;
    logic [SB-1:0]             s_mag;
    logic [SB-1:0]             old_mag;
    logic [MAG_W-1:0]          sum_mag;
    logic [LEN_W-1:0]          wp_inc;
    logic [NUM_W-1:0]          lsq_ext;
    logic [NUM_W-1:0]          ssq_ext;
    logic [NUM_W-1:0]          num;
    logic signed [MQ_W:0]      mval;
    logic signed [MEXT_W-1:0]  mean_ext;
    logic [SDX_W-1:0]          sd_ext;

    logic                      sq_start, mul_start, vdiv_start, sqrt_start;
    logic                      ssq_busy, osq_busy, lsq_busy, msq_busy;
    logic                      mdiv_busy, vdiv_busy, sqrt_busy;
    logic [2*SB-1:0]           ssq_p, osq_p;
    logic [LSQ_W-1:0]          lsq_p;
    logic [SSQ_W-1:0]          msq_p;
    logic [MQ_W-1:0]           mq;
    logic [VQ_W-1:0]           vq;
    logic [RT_W-1:0]           root;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = cfg_valid && cfg_ready;

    assign raw     = SB'(s_axis_tdata);
    assign pos_sel = (LEN_W'(wp_reg) >= len_reg) ? '0 : wp_reg;
    assign old_val = (LEN_W'(pos_reg) < fill_reg) ? $signed(rd_data_reg) : '0;
    assign s_mag   = s_reg[SB-1] ? SB'(-s_reg) : SB'(s_reg);
    assign old_mag = old_val[SB-1] ? SB'(-old_val) : SB'(old_val);
    assign sum_mag = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);

    assign sq_start   = (state_reg == S_LOAD);
    assign mul_start  = (state_reg == S_STRT);
    assign vdiv_start = (state_reg == S_MUL) && !(lsq_busy || msq_busy || mdiv_busy);
    assign sqrt_start = (state_reg == S_VDIV) && !vdiv_busy;

    // effective window length from the written value
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_data);
        if (cfg_ext == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (cfg_ext > CMP_W'(WINDOW_MAX))
        begin
            len_eff = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = LEN_W'(cfg_ext);
        end
    end

    // variance numerator, clamped at zero
    always_comb
    begin
        lsq_ext = NUM_W'(lsq_p);
        ssq_ext = NUM_W'(msq_p);
        num     = (lsq_ext > ssq_ext) ? (lsq_ext - ssq_ext) : '0;
    end

    always_comb
    begin
        mval     = sum_reg[SUM_W-1] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
        mean_ext = MEXT_W'(mval);
        sd_ext   = SDX_W'(root);
        wp_inc   = LEN_W'(pos_reg) + LEN_W'(1);
    end

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        len_sq_next  = len_sq_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        s_next       = s_reg;
        pos_next     = pos_reg;
        old_next     = old_reg;
        mean_next    = mean_reg;
        sd_next      = sd_reg;
        full_next    = full_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    s_next     = $signed(raw);
                    pos_next   = pos_sel;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                old_next   = old_val;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                if (!(ssq_busy || osq_busy))
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                sum_next   = sum_reg + SUM_W'(s_reg) - SUM_W'(old_reg);
                sq_next    = sq_reg + SQ_W'(ssq_p) - SQ_W'(osq_p);
                wp_next    = (wp_inc >= len_reg) ? '0 : PTR_W'(wp_inc);
                fill_next  = (fill_reg < len_reg) ? fill_reg + LEN_W'(1) : len_reg;
                state_next = S_STRT;
            end
            S_STRT:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (vdiv_start)
                begin
                    state_next = S_VDIV;
                end
            end
            S_VDIV:
            begin
                if (sqrt_start)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (!sqrt_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    mean_next    = mean_ext[MEAN_W-1:0];
                    sd_next      = sd_ext[SD_W-1:0];
                    full_next    = (fill_reg >= len_reg);
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a window length write clears the window
        if (cfg_acc)
        begin
            len_next    = len_eff;
            len_sq_next = VDS_W'(len_eff) * VDS_W'(len_eff);
            sum_next    = '0;
            sq_next     = '0;
            wp_next     = '0;
            fill_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= LEN_W'(1);
            len_sq_reg  <= VDS_W'(1);
            sum_reg     <= '0;
            sq_reg      <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            s_reg       <= '0;
            pos_reg     <= '0;
            old_reg     <= '0;
            mean_reg    <= '0;
            sd_reg      <= '0;
            full_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            len_sq_reg  <= len_sq_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            s_reg       <= s_next;
            pos_reg     <= pos_next;
            old_reg     <= old_next;
            mean_reg    <= mean_next;
            sd_reg      <= sd_next;
            full_reg    <= full_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // sample ring; entries at or past the fill count read as zero
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            ring[pos_reg] <= s_reg;
        end
        if (in_acc)
        begin
            rd_data_reg <= ring[pos_sel];
        end
    end

    mws_serial_mul #(.AW(SB), .BW(SB)) u_new_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .a       (s_mag),
        .b       (s_mag),
        .busy    (ssq_busy),
        .product (ssq_p)
    );

    mws_serial_mul #(.AW(SB), .BW(SB)) u_old_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .a       (old_mag),
        .b       (old_mag),
        .busy    (osq_busy),
        .product (osq_p)
    );

    mws_serial_mul #(.AW(LEN_W), .BW(SQ_W)) u_len_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (len_reg),
        .b       (sq_reg),
        .busy    (lsq_busy),
        .product (lsq_p)
    );

    mws_serial_mul #(.AW(MAG_W), .BW(MAG_W)) u_sum_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (sum_mag),
        .b       (sum_mag),
        .busy    (msq_busy),
        .product (msq_p)
    );

    mws_serial_div #(.DVS_W(LEN_W), .Q_W(MQ_W)) u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .dividend ((LEN_W + MQ_W)'({sum_mag, {FRAC_BITS{1'b0}}})),
        .divisor  (len_reg),
        .busy     (mdiv_busy),
        .quotient (mq)
    );

    mws_serial_div #(.DVS_W(VDS_W), .Q_W(VQ_W)) u_var_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (vdiv_start),
        .dividend ((VDS_W + VQ_W)'({num, {(2 * FRAC_BITS){1'b0}}})),
        .divisor  (len_sq_reg),
        .busy     (vdiv_busy),
        .quotient (vq)
    );

    mws_serial_sqrt #(.R(RT_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (vq),
        .busy     (sqrt_busy),
        .root     (root)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {sd_reg, mean_reg};
    assign m_axis_tuser  = full_reg;
    assign cfg_ready     = 1'b1;

endmodule
